// ----- design/msq_pkg.sv -----
`timescale 1ns / 1ps
// Package for the marching squares cell contour unit.
// Holds the per-case segment tables and shared types; depends on nothing.
package msq_pkg;

    localparam int WEIGHT_W = 16;
    localparam int CELL_W   = 10;
    localparam int COORD_W  = 11;
    localparam int CASE_W   = 4;

    localparam logic [1:0] EDGE_TOP    = 2'd0;
    localparam logic [1:0] EDGE_LEFT   = 2'd1;
    localparam logic [1:0] EDGE_BOTTOM = 2'd2;
    localparam logic [1:0] EDGE_RIGHT  = 2'd3;

    localparam logic [3:0] CASE_EMPTY = 4'b0000;
    localparam logic [3:0] CASE_FULL  = 4'b1111;
    localparam logic [3:0] CASE_SADDLE_A = 4'd6;
    localparam logic [3:0] CASE_SADDLE_B = 4'd9;

    typedef struct packed {
        logic [1:0] e1;
        logic [1:0] e2;
    } t_edge_pair;

    function automatic t_edge_pair seg_edges(input logic [3:0] idx, input logic second);
        t_edge_pair p;
        p = '{EDGE_TOP, EDGE_TOP};
        case (idx)
            4'd1, 4'd14: p = '{EDGE_TOP, EDGE_LEFT};
            4'd2, 4'd13: p = '{EDGE_TOP, EDGE_RIGHT};
            4'd3, 4'd12: p = '{EDGE_LEFT, EDGE_RIGHT};
            4'd4, 4'd11: p = '{EDGE_LEFT, EDGE_BOTTOM};
            4'd5, 4'd10: p = '{EDGE_TOP, EDGE_BOTTOM};
            CASE_SADDLE_A: p = second ? t_edge_pair'{EDGE_LEFT, EDGE_BOTTOM}
                                      : t_edge_pair'{EDGE_TOP, EDGE_RIGHT};
            4'd7, 4'd8: p = '{EDGE_BOTTOM, EDGE_RIGHT};
            CASE_SADDLE_B: p = second ? t_edge_pair'{EDGE_TOP, EDGE_LEFT}
                                      : t_edge_pair'{EDGE_BOTTOM, EDGE_RIGHT};
            default: p = '{EDGE_TOP, EDGE_TOP};
        endcase
        return p;
    endfunction

endpackage

// ----- design/msq_lerp_lane.sv -----
`timescale 1ns / 1ps
// One inverse-lerp lane: (iso - a) / (b - a) as a restoring divider, one
// quotient bit per stage. Depends on msq_pkg.
module msq_lerp_lane
    import msq_pkg::*;
#(
    parameter int FRAC_BITS = 10
) (
    input  logic                i_clk,
    input  logic                i_adv,
    input  logic [WEIGHT_W-1:0] i_a,
    input  logic [WEIGHT_W-1:0] i_b,
    input  logic [WEIGHT_W-1:0] i_iso,
    output logic [COORD_W-1:0]  o_t
);
    localparam int NS  = FRAC_BITS + 2;
    localparam int RW  = WEIGHT_W + 1;
    localparam int ONE = 1 << FRAC_BITS;

    logic [RW-1:0]        r_rem [NS];
    logic [WEIGHT_W-1:0]  r_den [NS];
    logic [FRAC_BITS-1:0] r_q   [NS];
    logic                 r_sat [NS];
    logic                 r_zero[NS];

    logic num_neg, den_neg;
    logic [WEIGHT_W-1:0] num0, den0;

    assign num_neg = i_iso < i_a;
    assign den_neg = i_b < i_a;
    assign num0 = num_neg ? i_a - i_iso : i_iso - i_a;
    assign den0 = den_neg ? i_a - i_b : i_b - i_a;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem[0]  <= {1'b0, num0};
            r_den[0]  <= den0;
            r_q[0]    <= '0;
            r_sat[0]  <= 1'b0;
            r_zero[0] <= (i_a == i_b) || ((i_iso != i_a) && (num_neg != den_neg));
            // saturate when the crossing lies a whole edge or more away
            r_rem[1]  <= r_rem[0];
            r_den[1]  <= r_den[0];
            r_q[1]    <= r_q[0];
            r_sat[1]  <= r_sat[0] || (r_rem[0] >= {1'b0, r_den[0]});
            r_zero[1] <= r_zero[0];
            for (int s = 1; s < NS - 1; s++) begin
                if ({r_rem[s][RW-2:0], 1'b0} >= {1'b0, r_den[s]}) begin
                    r_rem[s+1] <= {r_rem[s][RW-2:0], 1'b0} - {1'b0, r_den[s]};
                    r_q[s+1]   <= {r_q[s][FRAC_BITS-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= {r_rem[s][RW-2:0], 1'b0};
                    r_q[s+1]   <= {r_q[s][FRAC_BITS-2:0], 1'b0};
                end
                r_den[s+1]  <= r_den[s];
                r_sat[s+1]  <= r_sat[s];
                r_zero[s+1] <= r_zero[s];
            end
        end
    end

    always_comb begin
        if (r_zero[NS-1]) o_t = '0;
        else if (r_sat[NS-1]) o_t = COORD_W'(ONE);
        else o_t = COORD_W'(r_q[NS-1]);
    end
endmodule

// ----- design/marching_squares_cell_contour_unit.sv -----
`timescale 1ns / 1ps
// Top level of the marching squares cell contour unit.
// Depends on msq_pkg and msq_lerp_lane.
//
// Usage:
//   Input channel: one cell per request (position and four Q8.8 corner
//   weights), taken when i_in_valid is high and o_in_stall is low.
//   Output channel: one segment per request, o_out_valid / i_out_stall.
//   Cells with all four corners on one side of the level, and cells on the
//   last row or column, give nothing; saddle cells give two segments, and
//   last_segment marks the final one.
//   i_iso_we writes the iso level (reset 256 = 1.0); the user is to write
//   it only while idle, which the block itself does not enforce. Four divider
//   lanes (one per cell edge) take one stage for the whole part and one
//   quotient bit per stage after it; an accepted cell passes the lane stages
//   and then the output register. One cell is taken per cycle while
//   o_in_stall is low; a saddle cell gives its two segments in turn and holds
//   the pipe until its first one is taken. Stalling a waiting segment freezes
//   the whole pipe, and o_in_stall follows i_out_stall in the same cycle.
//   Reset (synchronous, active low) empties the pipe and restores the level.
module marching_squares_cell_contour_unit
    import msq_pkg::*;
#(
    parameter int GRID_DIM  = 1024,
    parameter int FRAC_BITS = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_iso_we,
    input  logic [WEIGHT_W-1:0] i_iso_level,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [CELL_W-1:0]   i_cell_x,
    input  logic [CELL_W-1:0]   i_cell_y,
    input  logic [WEIGHT_W-1:0] i_weight_top_left,
    input  logic [WEIGHT_W-1:0] i_weight_top_right,
    input  logic [WEIGHT_W-1:0] i_weight_bottom_left,
    input  logic [WEIGHT_W-1:0] i_weight_bottom_right,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [CELL_W-1:0]   o_seg_cell_x,
    output logic [CELL_W-1:0]   o_seg_cell_y,
    output logic [CASE_W-1:0]   o_case_index,
    output logic [COORD_W-1:0]  o_start_x,
    output logic [COORD_W-1:0]  o_start_z,
    output logic [COORD_W-1:0]  o_end_x,
    output logic [COORD_W-1:0]  o_end_z,
    output logic                o_last_segment
);
    localparam int LAT = FRAC_BITS + 2;

    logic [WEIGHT_W-1:0] r_iso;
    logic [COORD_W-1:0]  t [4];
    logic                adv;
    logic                inb;
    logic [3:0]          idx;

    logic             r_v    [LAT];
    logic [CELL_W-1:0] r_x   [LAT];
    logic [CELL_W-1:0] r_y   [LAT];
    logic [3:0]       r_idx  [LAT];

    logic             r_ov, r_osec;
    logic [CELL_W-1:0] r_ox, r_oy;
    logic [3:0]       r_oidx;
    logic [COORD_W-1:0] r_t [4];
    logic             hold2;
    logic [COORD_W-1:0] px [4], pz [4];
    t_edge_pair       ep;
    logic             saddle;

    assign saddle = r_oidx == CASE_SADDLE_A || r_oidx == CASE_SADDLE_B;
    // a saddle blocks the pipe while its first segment is shown
    assign hold2  = r_ov && saddle && !r_osec;
    assign adv    = !(r_ov && i_out_stall) && !hold2;
    assign o_in_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_iso <= 16'd256;
        else if (i_iso_we) r_iso <= i_iso_level;
    end

    assign inb = (32'(i_cell_x) + 1 < GRID_DIM) && (32'(i_cell_y) + 1 < GRID_DIM);
    assign idx = {i_weight_bottom_right > r_iso, i_weight_bottom_left > r_iso,
                  i_weight_top_right > r_iso, i_weight_top_left > r_iso};

    msq_lerp_lane #(.FRAC_BITS(FRAC_BITS)) u_top (.i_clk, .i_adv(adv),
        .i_a(i_weight_top_left), .i_b(i_weight_top_right), .i_iso(r_iso), .o_t(t[0]));
    msq_lerp_lane #(.FRAC_BITS(FRAC_BITS)) u_left (.i_clk, .i_adv(adv),
        .i_a(i_weight_top_left), .i_b(i_weight_bottom_left), .i_iso(r_iso), .o_t(t[1]));
    msq_lerp_lane #(.FRAC_BITS(FRAC_BITS)) u_bot (.i_clk, .i_adv(adv),
        .i_a(i_weight_bottom_left), .i_b(i_weight_bottom_right), .i_iso(r_iso), .o_t(t[2]));
    msq_lerp_lane #(.FRAC_BITS(FRAC_BITS)) u_right (.i_clk, .i_adv(adv),
        .i_a(i_weight_top_right), .i_b(i_weight_bottom_right), .i_iso(r_iso), .o_t(t[3]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LAT; s++) r_v[s] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_in_valid && inb && idx != CASE_EMPTY && idx != CASE_FULL;
            for (int s = 1; s < LAT; s++) r_v[s] <= r_v[s-1];
        end
        if (adv) begin
            r_x[0] <= i_cell_x;
            r_y[0] <= i_cell_y;
            r_idx[0] <= idx;
            for (int s = 1; s < LAT; s++) begin
                r_x[s] <= r_x[s-1];
                r_y[s] <= r_y[s-1];
                r_idx[s] <= r_idx[s-1];
            end
        end
    end

    // output register; merge the lanes per segment
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_osec <= 1'b0;
        end else if (hold2 && !i_out_stall) begin
            r_osec <= 1'b1;
        end else if (adv) begin
            r_ov   <= r_v[LAT-1];
            r_osec <= 1'b0;
        end
        if (adv) begin
            r_ox   <= r_x[LAT-1];
            r_oy   <= r_y[LAT-1];
            r_oidx <= r_idx[LAT-1];
            for (int e = 0; e < 4; e++) r_t[e] <= t[e];
        end
    end

    always_comb begin
        px[0] = r_t[0]; pz[0] = '0;
        px[1] = '0;     pz[1] = r_t[1];
        px[2] = r_t[2]; pz[2] = COORD_W'(1 << FRAC_BITS);
        px[3] = COORD_W'(1 << FRAC_BITS); pz[3] = r_t[3];
        ep = seg_edges(r_oidx, r_osec);
    end

    assign o_out_valid    = r_ov;
    assign o_seg_cell_x   = r_ox;
    assign o_seg_cell_y   = r_oy;
    assign o_case_index   = r_oidx;
    assign o_start_x      = px[ep.e1];
    assign o_start_z      = pz[ep.e1];
    assign o_end_x        = px[ep.e2];
    assign o_end_z        = pz[ep.e2];
    assign o_last_segment = !saddle || r_osec;
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for marching_squares_cell_contour_unit: a clocked driver and monitor
// check every segment against a predictor of the isoline cases. Depends on msq_pkg.
module tb_top
    import msq_pkg::*;
();

    localparam int GRID = 1024;
    localparam int FRAC = 10;
    localparam int LAT  = FRAC + 3;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic [CELL_W-1:0]   cx;
        logic [CELL_W-1:0]   cy;
        logic [WEIGHT_W-1:0] w0;
        logic [WEIGHT_W-1:0] w1;
        logic [WEIGHT_W-1:0] w2;
        logic [WEIGHT_W-1:0] w3;
    } t_cell;

    typedef struct packed {
        logic [CELL_W-1:0]  cx;
        logic [CELL_W-1:0]  cy;
        logic [CASE_W-1:0]  idx;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sz;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ez;
        logic               last;
    } t_seg;

    logic i_clk = 0, i_rst_n = 0;
    logic i_iso_we = 0;
    logic [WEIGHT_W-1:0] i_iso_level = 0;
    logic i_in_valid = 0, i_out_stall = 0;
    logic o_in_stall, o_out_valid;
    t_cell drv = '0;
    t_seg got;

    t_cell pending_cells[$];
    t_seg  expected_segs[$];
    logic [WEIGHT_W-1:0] iso_model = 16'd256;
    int send_idle = 0, recv_idle = 0;
    int phase = -1;
    logic long_hold = 1'b0;
    int mismatches = 0;
    int cycles = 0;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    marching_squares_cell_contour_unit #(.GRID_DIM(GRID), .FRAC_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_iso_we(i_iso_we), .i_iso_level(i_iso_level),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_cell_x(drv.cx), .i_cell_y(drv.cy),
        .i_weight_top_left(drv.w0), .i_weight_top_right(drv.w1),
        .i_weight_bottom_left(drv.w2), .i_weight_bottom_right(drv.w3),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_seg_cell_x(got.cx), .o_seg_cell_y(got.cy), .o_case_index(got.idx),
        .o_start_x(got.sx), .o_start_z(got.sz), .o_end_x(got.ex), .o_end_z(got.ez),
        .o_last_segment(got.last)
    );

    function automatic logic [COORD_W-1:0] edge_fraction(input logic [15:0] a,
                                                         input logic [15:0] b,
                                                         input logic [15:0] iso);
        logic [47:0] num, den, q;
        logic nneg, dneg;
        nneg = iso < a;
        dneg = b < a;
        if (a == b || (iso != a && nneg != dneg)) return '0;
        num = nneg ? 48'(a - iso) : 48'(iso - a);
        den = dneg ? 48'(a - b) : 48'(b - a);
        q = (num << FRAC) / den;
        if (q > (48'd1 << FRAC)) q = 48'd1 << FRAC;
        return q[COORD_W-1:0];
    endfunction

    task automatic predict_segments(input t_cell c);
        logic [3:0] idx;
        logic [COORD_W-1:0] px[4], pz[4];
        t_edge_pair p;
        t_seg s;
        int n;
        if (int'(c.cx) + 1 >= GRID || int'(c.cy) + 1 >= GRID) return;
        idx = {c.w3 > iso_model, c.w2 > iso_model, c.w1 > iso_model, c.w0 > iso_model};
        if (idx == CASE_EMPTY || idx == CASE_FULL) return;
        n = (idx == CASE_SADDLE_A || idx == CASE_SADDLE_B) ? 2 : 1;
        px[0] = edge_fraction(c.w0, c.w1, iso_model); pz[0] = '0;
        px[1] = '0; pz[1] = edge_fraction(c.w0, c.w2, iso_model);
        px[2] = edge_fraction(c.w2, c.w3, iso_model); pz[2] = 11'd1 << FRAC;
        px[3] = 11'd1 << FRAC; pz[3] = edge_fraction(c.w1, c.w3, iso_model);
        for (int k = 0; k < n; k++) begin
            case (idx)
                4'd1, 4'd14: p = '{EDGE_TOP, EDGE_LEFT};
                4'd2, 4'd13: p = '{EDGE_TOP, EDGE_RIGHT};
                4'd3, 4'd12: p = '{EDGE_LEFT, EDGE_RIGHT};
                4'd4, 4'd11: p = '{EDGE_LEFT, EDGE_BOTTOM};
                4'd5, 4'd10: p = '{EDGE_TOP, EDGE_BOTTOM};
                CASE_SADDLE_A: p = k ? t_edge_pair'{EDGE_LEFT, EDGE_BOTTOM}
                                     : t_edge_pair'{EDGE_TOP, EDGE_RIGHT};
                CASE_SADDLE_B: p = k ? t_edge_pair'{EDGE_TOP, EDGE_LEFT}
                                     : t_edge_pair'{EDGE_BOTTOM, EDGE_RIGHT};
                default: p = '{EDGE_BOTTOM, EDGE_RIGHT};
            endcase
            s = '{c.cx, c.cy, idx, px[p.e1], pz[p.e1], px[p.e2], pz[p.e2], k == n - 1};
            expected_segs.push_back(s);
        end
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // driver: hold a stalled request, advance on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) predict_segments(drv);
            if (!i_in_valid || !o_in_stall) begin
                if (pending_cells.size() > 0 && $urandom_range(99) >= send_idle) begin
                    drv <= pending_cells.pop_front();
                    i_in_valid <= 1;
                end else begin
                    i_in_valid <= 0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_segs.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected segment %p", got);
                end else begin
                    t_seg e;
                    e = expected_segs.pop_front();
                    if (e !== got) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10) $display("mismatch exp %p got %p", e, got);
                    end
                end
            end
            i_out_stall <= long_hold || ($urandom_range(99) < recv_idle);
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        wait (phase == 2);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (200) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    function automatic logic [15:0] near_level(input logic [15:0] iso);
        int v;
        case ($urandom_range(5))
            0: v = 0;
            1: v = 65535;
            2: v = int'(iso) + 1;
            3: v = int'(iso);
            default: v = int'(iso) + $urandom_range(600) - 300;
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[15:0];
    endfunction

    function automatic t_cell random_cell(input logic [15:0] iso);
        t_cell c;
        c.cx = $urandom_range(50) == 0 ? 10'd1023 : 10'($urandom);
        c.cy = $urandom_range(50) == 0 ? 10'd1023 : 10'($urandom);
        if ($urandom_range(9) == 0) begin
            c.w0 = 16'($urandom); c.w1 = 16'($urandom);
            c.w2 = 16'($urandom); c.w3 = 16'($urandom);
        end else begin
            c.w0 = near_level(iso); c.w1 = near_level(iso);
            c.w2 = near_level(iso); c.w3 = near_level(iso);
        end
        return c;
    endfunction

    task automatic drain_and_set(input logic [15:0] level);
        while (pending_cells.size() > 0 || i_in_valid || expected_segs.size() > 0)
            @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
        i_iso_we <= 1;
        i_iso_level <= level;
        iso_model = level;
        @(posedge i_clk);
        i_iso_we <= 0;
    endtask

    initial begin
        logic [15:0] levels[5];
        t_cell c;
        levels = '{16'd256, 16'd0, 16'd65535, 16'd4000, 16'($urandom)};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        for (int m = 0; m < 16; m++) begin
            c.cx = 10'(m * 37); c.cy = 10'(m * 11);
            c.w0 = m[0] ? 16'd300 : 16'd100; c.w1 = m[1] ? 16'd65535 : 16'd0;
            c.w2 = m[2] ? 16'd257 : 16'd256; c.w3 = m[3] ? 16'd1000 : 16'd200;
            pending_cells.push_back(c);
        end
        c = '{10'd1022, 10'd1022, 16'd0, 16'd65535, 16'd0, 16'd0};
        pending_cells.push_back(c);
        c.cx = 10'd1023; pending_cells.push_back(c);
        c.cx = 10'd0; c.cy = 10'd1023; pending_cells.push_back(c);
        c = '{10'h3fe, 10'h3fe, 16'hffff, 16'h0, 16'h0, 16'hffff};
        pending_cells.push_back(c);
        for (int ph = 0; ph < 5; ph++) begin
            drain_and_set(levels[ph]);
            send_idle = (ph % 3 == 0) ? 31 : (ph % 3 == 1) ? 58 : 0;
            recv_idle = (ph % 3 == 0) ? 58 : (ph % 3 == 1) ? 31 : 0;
            for (int i = 0; i < 250; i++) pending_cells.push_back(random_cell(iso_model));
            phase = ph;
        end
        while (pending_cells.size() > 0 || i_in_valid || expected_segs.size() > 0)
            @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
        if (mismatches == 0) $display("tb_top: PASS");
        else $display("tb_top: FAIL");
        $finish;
    end
endmodule

// ----- files.f -----
design/msq_pkg.sv
design/msq_lerp_lane.sv
design/marching_squares_cell_contour_unit.sv
tb/tb_top.sv
